FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk_i outside reset.
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Signal held stable in the cycle after the condition.
`define AST_HOLD(lbl, cond, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/hplp_pkg.sv
// Package with result types, codes and byte classes of the parameter list parser.
`timescale 1ns / 1ps
package hplp_pkg;

  typedef enum logic [2:0] {
    KIND_KEY  = 3'd0,
    KIND_VAL  = 3'd1,
    KIND_PAIR = 3'd2,
    KIND_DROP = 3'd3,
    KIND_ERR  = 3'd4,
    KIND_DONE = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_NAME  = 2'd1,
    ERR_VALUE = 2'd2,
    ERR_QUOTE = 2'd3
  } err_e;

  localparam int unsigned MaxRes    = 3;
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    err_e       code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]        cnt;
    res_t [MaxRes-1:0] res;
  } step_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_tok(input logic [7:0] c);
    logic t;
    t = ((c >= "0") && (c <= "9")) || ((c >= "A") && (c <= "Z")) ||
        ((c >= "a") && (c <= "z"));
    case (c)
      "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60, "|", "~": t = 1'b1;
      default: ;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/hplp_parser.sv
// Parser state and combinational step logic for one text byte.
`timescale 1ns / 1ps
module hplp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           go_i,
  input  logic [7:0]     byte_i,
  input  logic           fin_i,
  output hplp_pkg::step_t step_o
);
  import hplp_pkg::*;

  typedef enum logic [3:0] {
    PH_KEY_LEAD  = 4'd0,
    PH_KEY_BODY  = 4'd1,
    PH_KEY_TRAIL = 4'd2,
    PH_VAL_LEAD  = 4'd3,
    PH_VAL_BODY  = 4'd4,
    PH_VAL_TRAIL = 4'd5,
    PH_QUOTED    = 4'd6,
    PH_AFTER_Q   = 4'd7
  } phase_e;

  phase_e     phase_q, phase_d;
  logic       key_seen_q, key_seen_d;
  logic       key_inv_q, key_inv_d;
  logic       failed_q, failed_d;
  logic [1:0] n;
  res_t [MaxRes-1:0] res;

  always_comb begin
    phase_d    = phase_q;
    key_seen_d = key_seen_q;
    key_inv_d  = key_inv_q;
    failed_d   = failed_q;
    n          = 2'd0;
    res        = '0;
    if (!failed_q) begin
      case (phase_q)
        PH_KEY_LEAD, PH_KEY_BODY, PH_KEY_TRAIL: begin
          if (byte_i == "=") begin
            if (!key_seen_q || key_inv_q) begin
              failed_d = 1'b1;
              res[n] = '{KIND_ERR, 8'd0, ERR_NAME, 1'b0};
              n = n + 2'd1;
            end else begin
              phase_d    = PH_VAL_LEAD;
              key_seen_d = 1'b0;
              key_inv_d  = 1'b0;
            end
          end else if (is_ws(byte_i)) begin
            if (phase_q == PH_KEY_BODY) phase_d = PH_KEY_TRAIL;
          end else begin
            if ((phase_q == PH_KEY_TRAIL) || !is_tok(byte_i)) key_inv_d = 1'b1;
            key_seen_d = 1'b1;
            phase_d    = PH_KEY_BODY;
            res[n] = '{KIND_KEY, byte_i, ERR_NONE, 1'b0};
            n = n + 2'd1;
          end
        end
        PH_VAL_LEAD: begin
          if (is_ws(byte_i)) begin
            phase_d = PH_VAL_LEAD;
          end else if ((byte_i == "\"") && !fin_i) begin
            phase_d = PH_QUOTED;
          end else if (is_tok(byte_i)) begin
            phase_d = PH_VAL_BODY;
            res[n] = '{KIND_VAL, byte_i, ERR_NONE, 1'b0};
            n = n + 2'd1;
          end else begin
            failed_d = 1'b1;
            res[n] = '{KIND_ERR, 8'd0, ERR_VALUE, 1'b0};
            n = n + 2'd1;
          end
        end
        PH_VAL_BODY, PH_VAL_TRAIL: begin
          if (byte_i == ";") begin
            phase_d = PH_KEY_LEAD;
            res[n] = '{KIND_PAIR, 8'd0, ERR_NONE, 1'b0};
            n = n + 2'd1;
          end else if (is_ws(byte_i)) begin
            phase_d = PH_VAL_TRAIL;
          end else if ((phase_q == PH_VAL_BODY) && is_tok(byte_i)) begin
            res[n] = '{KIND_VAL, byte_i, ERR_NONE, 1'b0};
            n = n + 2'd1;
          end else begin
            failed_d = 1'b1;
            res[n] = '{KIND_ERR, 8'd0, ERR_VALUE, 1'b0};
            n = n + 2'd1;
          end
        end
        PH_QUOTED: begin
          if (byte_i == "\"") begin
            phase_d = PH_AFTER_Q;
            res[n] = '{KIND_PAIR, 8'd0, ERR_NONE, 1'b0};
          end else begin
            res[n] = '{KIND_VAL, byte_i, ERR_NONE, 1'b0};
          end
          n = n + 2'd1;
        end
        default: begin
          if (byte_i == ";") phase_d = PH_KEY_LEAD;
        end
      endcase
    end
    if (fin_i) begin
      if (!failed_d) begin
        case (phase_d)
          PH_KEY_LEAD, PH_KEY_BODY, PH_KEY_TRAIL: begin
            if (key_seen_d || key_inv_d) begin
              res[n] = '{KIND_DROP, 8'd0, ERR_NONE, 1'b0};
              n = n + 2'd1;
            end
          end
          PH_VAL_LEAD: begin
            res[n] = '{KIND_ERR, 8'd0, ERR_VALUE, 1'b0};
            n = n + 2'd1;
          end
          PH_VAL_BODY, PH_VAL_TRAIL: begin
            res[n] = '{KIND_PAIR, 8'd0, ERR_NONE, 1'b0};
            n = n + 2'd1;
          end
          PH_QUOTED: begin
            res[n] = '{KIND_ERR, 8'd0, ERR_QUOTE, 1'b0};
            n = n + 2'd1;
          end
          default: ;
        endcase
      end
      res[n] = '{KIND_DONE, 8'd0, ERR_NONE, 1'b0};
      n = n + 2'd1;
      phase_d    = PH_KEY_LEAD;
      key_seen_d = 1'b0;
      key_inv_d  = 1'b0;
      failed_d   = 1'b0;
    end
    for (int i = 0; i < MaxRes; i++) begin
      res[i].last = (2'(i + 1) == n);
    end
    step_o.cnt = n;
    step_o.res = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_KEY_LEAD;
      key_seen_q <= 1'b0;
      key_inv_q  <= 1'b0;
      failed_q   <= 1'b0;
    end else if (go_i) begin
      phase_q    <= phase_d;
      key_seen_q <= key_seen_d;
      key_inv_q  <= key_inv_d;
      failed_q   <= failed_d;
    end
  end

endmodule

FILE: rtl/core/hplp_result_fifo.sv
// Result queue that takes up to three results per cycle and gives one.
`timescale 1ns / 1ps
module hplp_result_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hplp_pkg::step_t step_i,
  output logic            space_o,
  output logic            valid_o,
  input  logic            ready_i,
  output hplp_pkg::res_t  res_o
);
  import hplp_pkg::*;

  res_t                mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoAw:0]     count_q, count_d;
  logic [1:0]          push_n;
  logic                pop;

  assign push_n  = push_i ? step_i.cnt : 2'd0;
  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign space_o = (count_q <= (FifoAw + 1)'(FifoDepth - MaxRes));
  assign res_o   = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + FifoAw'(push_n);
  assign rd_ptr_d = rd_ptr_q + FifoAw'(pop);
  assign count_d  = count_q + (FifoAw + 1)'(push_n) - (FifoAw + 1)'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (push_i && (2'(i) < step_i.cnt)) begin
        mem_q[wr_ptr_q + FifoAw'(i)] <= step_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/core/header_parameter_list_parser_unit.sv
// Top level of the header parameter list parser.
//
//  channel | dir | tdata                          | tuser    | tlast
//  s_axis  | in  | [7:0] in_byte                  | -        | is_final
//  m_axis  | out | [7:0] out_byte, [9:8] err code | [2:0] kind | last result of a byte
//
// One text word is taken per cycle while the queue has room; each word is held
// in an input register, and its results leave one per cycle, while m_axis_tready
// is high, through an eight-entry result queue. Any word holds the input back while
// the queue is short of three free entries; the output side sets the sustained rate.
// Reset returns the parser to key leading whitespace and empties the queue.
`timescale 1ns / 1ps
module header_parameter_list_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] error_code
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);
  import hplp_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_fin_q;
  logic       s_acc;
  logic       step_go;
  logic       space;
  step_t      step;
  res_t       head;

  assign step_go       = in_vld_q && space;
  assign s_axis_tready = !in_vld_q || space;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_acc) begin
      in_vld_q <= 1'b1;
    end else if (step_go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata;
      in_fin_q  <= s_axis_tlast;
    end
  end

  hplp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (step_go),
    .byte_i (in_byte_q),
    .fin_i  (in_fin_q),
    .step_o (step)
  );

  hplp_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step_go),
    .step_i  (step),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (head)
  );

  assign m_axis_tdata = {6'd0, head.code, head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

FILE: rtl/core/hplp_checker.sv
// Port-level checks of the parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hplp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import hplp_pkg::*;

  logic m_stall;
  logic s_stall;
  logic m_plain;

  assign m_stall = m_axis_tvalid && !m_axis_tready;
  assign s_stall = s_axis_tvalid && !s_axis_tready;
  assign m_plain = m_axis_tvalid && (m_axis_tuser != KIND_KEY) && (m_axis_tuser != KIND_VAL);

  `AST_HOLD(a_out_hold, m_stall, {m_axis_tdata, m_axis_tuser, m_axis_tlast})
  `AST_HOLD(a_in_hold, s_stall, {s_axis_tvalid, s_axis_tdata, s_axis_tlast})
  `AST_IMPL(a_done_last, m_axis_tvalid && (m_axis_tuser == KIND_DONE), m_axis_tlast)
  `AST_IMPL(a_code_err, m_axis_tvalid && (m_axis_tuser != KIND_ERR), m_axis_tdata[9:8] == ERR_NONE)
  `AST_IMPL(a_byte_zero, m_plain, m_axis_tdata[7:0] == 8'd0)

endmodule

bind header_parameter_list_parser_unit hplp_checker u_hplp_checker (.*);
